// ===== hw/rtl/chae_pkg.sv =====
`timescale 1ns / 1ps

package chae_pkg;

  // request types
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_BUILD  = 2'd1;
  localparam logic [1:0] REQ_ENCODE = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_BUILT = 2'd1;
  localparam logic [1:0] STAT_NO_CODE   = 2'd2;

  // fixed field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned STAT_W  = 2;

  // parameter defaults
  localparam int unsigned NUM_SYMBOLS_DEF  = 256;
  localparam int unsigned MAX_CODE_LEN_DEF = 32;

endpackage

// ===== hw/rtl/chae_len_store.sv =====
`timescale 1ns / 1ps

// code length table, one write and one registered read per cycle;
// an entry never written since reset reads as zero
module chae_len_store #(
  parameter int unsigned NUM_SYMBOLS = chae_pkg::NUM_SYMBOLS_DEF,
  parameter int unsigned IDX_W       = $clog2(NUM_SYMBOLS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [chae_pkg::LEN_W-1:0] wr_data,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic [chae_pkg::LEN_W-1:0] rd_data
);

  logic [chae_pkg::LEN_W-1:0] mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0]     vld_r;
  logic [chae_pkg::LEN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/chae_code_store.sv =====
`timescale 1ns / 1ps

// canonical code table, filled by a build; users must read it only after a build, which this store does not enforce
module chae_code_store #(
  parameter int unsigned NUM_SYMBOLS = chae_pkg::NUM_SYMBOLS_DEF,
  parameter int unsigned IDX_W       = $clog2(NUM_SYMBOLS)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [chae_pkg::CODE_W-1:0] wr_data,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [chae_pkg::CODE_W-1:0] rd_data
);

  logic [chae_pkg::CODE_W-1:0] mem [NUM_SYMBOLS];
  logic [chae_pkg::CODE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/chae_code_step.sv =====
`timescale 1ns / 1ps

// one canonical assignment step: shift by length growth, mask, increment
module chae_code_step (
  input  logic [chae_pkg::CODE_W-1:0] code_in,
  input  logic [chae_pkg::LEN_W-1:0]  prev_len,
  input  logic [chae_pkg::LEN_W-1:0]  cur_len,
  output logic [chae_pkg::CODE_W-1:0] code_out,
  output logic [chae_pkg::CODE_W-1:0] code_next
);

  logic [chae_pkg::LEN_W-1:0]  shamt;
  logic [chae_pkg::CODE_W-1:0] shifted;
  logic [chae_pkg::CODE_W-1:0] mask;

  always_comb begin
    if ((prev_len != '0) && (cur_len > prev_len)) begin
      shamt = cur_len - prev_len;
    end else begin
      shamt = '0;
    end
    shifted   = code_in << shamt;
    // a shift by the full width gives zero, so a full-length mask is all ones
    mask      = ~({chae_pkg::CODE_W{1'b1}} << cur_len);
    code_out  = shifted & mask;
    code_next = code_out + chae_pkg::CODE_W'(1);
  end

endmodule

// ===== hw/rtl/canonical_huffman_assign_encode.sv =====
// flow: load and unused requests go straight to the result register; encode passes through
// ST_ENC; build walks ST_BUILD (one length table read per symbol per length), then ST_DRAIN
// throughput: one transaction at a time; the next is taken once the result has been taken
// reset: synchronous active low; clears length table valid bits, codes-built flag,
// bit total and all handshake state; the code table is only read after a build fills it
`timescale 1ns / 1ps

module canonical_huffman_assign_encode #(
  parameter int unsigned NUM_SYMBOLS  = chae_pkg::NUM_SYMBOLS_DEF,
  parameter int unsigned MAX_CODE_LEN = chae_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [chae_pkg::REQ_W-1:0]   in_req_type,
  input  logic [chae_pkg::SYM_W-1:0]   in_symbol,
  input  logic [chae_pkg::LEN_W-1:0]   in_length_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [chae_pkg::STAT_W-1:0]  out_status,
  output logic [chae_pkg::CODE_W-1:0]  out_code_word,
  output logic [chae_pkg::LEN_W-1:0]   out_code_len,
  output logic [chae_pkg::TOTAL_W-1:0] out_total_bits
);

  localparam int unsigned IDX_W = $clog2(NUM_SYMBOLS);
  localparam logic [chae_pkg::SYM_W:0]   SYM_LIMIT = (chae_pkg::SYM_W + 1)'(NUM_SYMBOLS);
  localparam logic [IDX_W-1:0]           LAST_SYM  = IDX_W'(NUM_SYMBOLS - 1);
  localparam logic [chae_pkg::LEN_W-1:0] MAX_LEN   = chae_pkg::LEN_W'(MAX_CODE_LEN);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ENC   = 2'd1;
  localparam logic [1:0] ST_BUILD = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state_r, state_nxt;

  // control state
  logic codes_ready_r, codes_ready_nxt;
  logic pend_vld_r, pend_vld_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [chae_pkg::TOTAL_W-1:0] total_r, total_nxt;

  // build walk: scan issues length reads, pend holds the read in flight
  logic [IDX_W-1:0]           scan_sym_r, scan_sym_nxt;
  logic [chae_pkg::LEN_W-1:0] scan_len_r, scan_len_nxt;
  logic [IDX_W-1:0]           pend_sym_r, pend_sym_nxt;
  logic [chae_pkg::LEN_W-1:0] pend_len_r, pend_len_nxt;
  logic [chae_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [chae_pkg::LEN_W-1:0]  prev_r, prev_nxt;
  logic enc_sym_ok_r, enc_sym_ok_nxt;

  // result register
  logic [chae_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [chae_pkg::CODE_W-1:0] word_r, word_nxt;
  logic [chae_pkg::LEN_W-1:0]  clen_r, clen_nxt;

  logic                         acc;
  logic                         sym_ok;
  logic [IDX_W-1:0]             sym_idx;
  logic [chae_pkg::LEN_W-1:0]   len_clamped;
  logic                         len_wr_en;
  logic [IDX_W-1:0]             len_rd_addr;
  logic [chae_pkg::LEN_W-1:0]   len_rd;
  logic [chae_pkg::CODE_W-1:0]  code_rd;
  logic                         hit;
  logic [chae_pkg::CODE_W-1:0]  step_code;
  logic [chae_pkg::CODE_W-1:0]  step_next;
  logic [chae_pkg::TOTAL_W:0]   sum;

  // one transaction in flight; the result register must be empty to take one
  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign acc       = in_valid && in_ready;
  assign sym_ok    = {1'b0, in_symbol} < SYM_LIMIT;
  assign sym_idx   = in_symbol[IDX_W-1:0];
  assign len_clamped = (in_length_in > MAX_LEN) ? MAX_LEN : in_length_in;
  assign len_wr_en = acc && (in_req_type == chae_pkg::REQ_LOAD) && sym_ok;

  // the length table is walked during a build, else looked up by the request
  assign len_rd_addr = (state_r == ST_BUILD) ? scan_sym_r : sym_idx;

  // a symbol whose stored length matches the length being walked gets the next code
  assign hit = pend_vld_r && (len_rd == pend_len_r);

  // saturating bit total for encode
  assign sum = {1'b0, total_r} + (chae_pkg::TOTAL_W + 1)'(len_rd);

  chae_len_store #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .IDX_W       (IDX_W)
  ) u_len_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (len_wr_en),
    .wr_addr (sym_idx),
    .wr_data (len_clamped),
    .rd_addr (len_rd_addr),
    .rd_data (len_rd)
  );

  chae_code_store #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .IDX_W       (IDX_W)
  ) u_code_store (
    .clk     (clk),
    .wr_en   (hit),
    .wr_addr (pend_sym_r),
    .wr_data (step_code),
    .rd_addr (sym_idx),
    .rd_data (code_rd)
  );

  // shared shift / mask / increment unit, used once per matching symbol
  chae_code_step u_code_step (
    .code_in   (code_r),
    .prev_len  (prev_r),
    .cur_len   (pend_len_r),
    .code_out  (step_code),
    .code_next (step_next)
  );

  always_comb begin
    state_nxt       = state_r;
    codes_ready_nxt = codes_ready_r;
    pend_vld_nxt    = 1'b0;
    out_valid_nxt   = out_valid_r;
    total_nxt       = total_r;
    scan_sym_nxt    = scan_sym_r;
    scan_len_nxt    = scan_len_r;
    pend_sym_nxt    = scan_sym_r;
    pend_len_nxt    = scan_len_r;
    code_nxt        = code_r;
    prev_nxt        = prev_r;
    enc_sym_ok_nxt  = enc_sym_ok_r;
    status_nxt      = status_r;
    word_nxt        = word_r;
    clen_nxt        = clen_r;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // build evaluation stage, works on the registered result of the read it issued in the cycle before
    if (hit) begin
      code_nxt = step_next;
      prev_nxt = pend_len_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          // default result for load, build start and unused types
          status_nxt = chae_pkg::STAT_OK;
          word_nxt   = '0;
          clen_nxt   = '0;
          case (in_req_type)
            chae_pkg::REQ_LOAD: begin
              out_valid_nxt = 1'b1;
              if (sym_ok) begin
                codes_ready_nxt = 1'b0;
              end
            end
            chae_pkg::REQ_BUILD: begin
              state_nxt    = ST_BUILD;
              scan_sym_nxt = '0;
              scan_len_nxt = chae_pkg::LEN_W'(1);
              code_nxt     = '0;
              prev_nxt     = '0;
            end
            chae_pkg::REQ_ENCODE: begin
              state_nxt      = ST_ENC;
              enc_sym_ok_nxt = sym_ok;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_ENC: begin
        // table reads are back, form the encode result
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        word_nxt      = '0;
        clen_nxt      = '0;
        if (!codes_ready_r) begin
          status_nxt = chae_pkg::STAT_NOT_BUILT;
        end else if (!enc_sym_ok_r || (len_rd == '0)) begin
          status_nxt = chae_pkg::STAT_NO_CODE;
        end else begin
          status_nxt = chae_pkg::STAT_OK;
          word_nxt   = code_rd;
          clen_nxt   = len_rd;
          total_nxt  = sum[chae_pkg::TOTAL_W] ? '1 : sum[chae_pkg::TOTAL_W-1:0];
        end
      end
      ST_BUILD: begin
        // walk (length, symbol) in canonical order, one read per cycle
        pend_vld_nxt = 1'b1;
        if (scan_sym_r == LAST_SYM) begin
          scan_sym_nxt = '0;
          if (scan_len_r == MAX_LEN) begin
            state_nxt = ST_DRAIN;
          end else begin
            scan_len_nxt = scan_len_r + chae_pkg::LEN_W'(1);
          end
        end else begin
          scan_sym_nxt = scan_sym_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // last symbol evaluated this cycle; codes are complete
        state_nxt       = ST_IDLE;
        codes_ready_nxt = 1'b1;
        out_valid_nxt   = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      codes_ready_r <= 1'b0;
      pend_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      total_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      codes_ready_r <= codes_ready_nxt;
      pend_vld_r    <= pend_vld_nxt;
      out_valid_r   <= out_valid_nxt;
      total_r       <= total_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    scan_sym_r   <= scan_sym_nxt;
    scan_len_r   <= scan_len_nxt;
    pend_sym_r   <= pend_sym_nxt;
    pend_len_r   <= pend_len_nxt;
    code_r       <= code_nxt;
    prev_r       <= prev_nxt;
    enc_sym_ok_r <= enc_sym_ok_nxt;
    status_r     <= status_nxt;
    word_r       <= word_nxt;
    clen_r       <= clen_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_code_word  = word_r;
  assign out_code_len   = clen_r;
  assign out_total_bits = total_r;

endmodule
